[hw/rtl/utf8_to_utf16_transcoder_unit_macros.svh]
// assertion macros for the utf-8 to utf-16 transcoder
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge outside reset
`define U8U16_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed");

// ante at an edge implies cons at the same edge
`define U8U16_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define U8U16_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define U8U16_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/u8u16_pkg.sv]
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam logic [20:0] CodeMax       = 21'h10FFFF;
  localparam logic [20:0] SurrogateLo   = 21'h00D800;
  localparam logic [20:0] SurrogateHi   = 21'h00DFFF;
  localparam logic [20:0] SupplBase     = 21'h010000;
  localparam logic [20:0] TwoByteMin    = 21'h000080;
  localparam logic [20:0] ThreeByteMin  = 21'h000800;
  localparam logic [5:0]  HighSurrTag   = 6'b110110;
  localparam logic [5:0]  LowSurrTag    = 6'b110111;

  // continuation counts of a character
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  // result counts per input byte
  localparam logic [1:0] ResNone = 2'd0;
  localparam logic [1:0] ResOne  = 2'd1;
  localparam logic [1:0] ResTwo  = 2'd2;

  // output queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueLvlW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        bad_input;
    logic        final_unit;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic [1:0]  sequence_length;
    logic [20:0] code_accumulator;
    logic        discarding;
  } dec_state_t;

  // results produced by one byte, pushed to the queue together
  typedef struct packed {
    logic [1:0] res_count;
    out_item_t  unit0;
    out_item_t  unit1;
  } dec_push_t;

endpackage

[hw/rtl/u8u16_decoder.sv]
`timescale 1ns / 1ps

module u8u16_decoder
  import u8u16_pkg::*;
(
  input  in_item_t   item_i,
  input  dec_state_t state_i,
  output dec_state_t state_o,
  output dec_push_t  push_o
);

  logic [7:0]  b;
  logic        last;
  logic [20:0] acc_shift;
  logic [1:0]  pend_dec;
  logic        overlong;
  logic        out_of_range;
  logic        do_fail;
  logic        do_emit;
  logic [20:0] emit_cp;
  logic [20:0] suppl_off;

  assign b         = item_i.byte_in;
  assign last      = item_i.end_of_text;
  assign acc_shift = {state_i.code_accumulator[14:0], b[5:0]};
  assign pend_dec  = state_i.bytes_pending - 2'd1;
  assign suppl_off = emit_cp - SupplBase;

  always_comb begin
    overlong = ((state_i.sequence_length == SeqTwo)   && (acc_shift < TwoByteMin))   ||
               ((state_i.sequence_length == SeqThree) && (acc_shift < ThreeByteMin)) ||
               ((state_i.sequence_length == SeqFour)  && (acc_shift < SupplBase));
    out_of_range = (acc_shift > CodeMax) ||
                   ((acc_shift >= SurrogateLo) && (acc_shift <= SurrogateHi));
  end

  // next state and which kind of result
  always_comb begin
    state_o = state_i;
    do_fail = 1'b0;
    do_emit = 1'b0;
    emit_cp = acc_shift;
    if (state_i.discarding) begin
      state_o.discarding = ~last;
    end else if (state_i.bytes_pending == 2'd0) begin
      if (!b[7]) begin
        do_emit = 1'b1;
        emit_cp = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        state_o.code_accumulator = {16'd0, b[4:0]};
        state_o.sequence_length  = SeqTwo;
        state_o.bytes_pending    = SeqTwo;
        do_fail = last;
      end else if (b[7:4] == 4'b1110) begin
        state_o.code_accumulator = {17'd0, b[3:0]};
        state_o.sequence_length  = SeqThree;
        state_o.bytes_pending    = SeqThree;
        do_fail = last;
      end else if (b[7:3] == 5'b11110) begin
        state_o.code_accumulator = {18'd0, b[2:0]};
        state_o.sequence_length  = SeqFour;
        state_o.bytes_pending    = SeqFour;
        do_fail = last;
      end else begin
        do_fail = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      do_fail = 1'b1;
    end else if (pend_dec != 2'd0) begin
      state_o.code_accumulator = acc_shift;
      state_o.bytes_pending    = pend_dec;
      do_fail = last;
    end else begin
      state_o.code_accumulator = '0;
      state_o.sequence_length  = 2'd0;
      state_o.bytes_pending    = 2'd0;
      if (overlong || out_of_range) begin
        do_fail = 1'b1;
      end else begin
        do_emit = 1'b1;
      end
    end
    if (do_fail) begin
      state_o.code_accumulator = '0;
      state_o.sequence_length  = 2'd0;
      state_o.bytes_pending    = 2'd0;
      state_o.discarding       = ~last;
    end
  end

  // result units
  always_comb begin
    push_o = '0;
    if (do_fail) begin
      push_o.res_count        = ResOne;
      push_o.unit0.bad_input  = 1'b1;
      push_o.unit0.final_unit = 1'b1;
    end else if (do_emit) begin
      if (emit_cp < SupplBase) begin
        push_o.res_count        = ResOne;
        push_o.unit0.code_unit  = emit_cp[15:0];
        push_o.unit0.final_unit = last;
      end else begin
        // surrogate pair, high half first
        push_o.res_count        = ResTwo;
        push_o.unit0.code_unit  = {HighSurrTag, suppl_off[19:10]};
        push_o.unit1.code_unit  = {LowSurrTag, suppl_off[9:0]};
        push_o.unit1.final_unit = last;
      end
    end else begin
      push_o.res_count = ResNone;
    end
  end

endmodule

[hw/rtl/u8u16_out_queue.sv]
`timescale 1ns / 1ps

module u8u16_out_queue
  import u8u16_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_en_i,
  input  dec_push_t            push_i,
  output logic [QueueLvlW-1:0] level_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  out_item_t              entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueLvlW-1:0]   level_q, level_d;
  logic [1:0]             push_n;
  logic                   pop;
  logic [QueuePtrW-1:0]   wr_ptr_nxt;

  assign push_n      = push_en_i ? push_i.res_count : ResNone;
  assign out_valid_o = (level_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nxt  = wr_ptr_q + QueuePtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_n);
    rd_ptr_d = rd_ptr_q + QueuePtrW'(pop);
    level_d  = level_q + QueueLvlW'(push_n) - QueueLvlW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != ResNone) begin
      entry_q[wr_ptr_q] <= push_i.unit0;
    end
    if (push_n == ResTwo) begin
      entry_q[wr_ptr_nxt] <= push_i.unit1;
    end
  end

  assign out_item_o = entry_q[rd_ptr_q];
  assign level_o    = level_q;

endmodule

[hw/rtl/utf8_to_utf16_transcoder_unit.sv]
`timescale 1ns / 1ps

// utf-8 to utf-16 transcoder: takes one byte of a utf-8 string per transaction
// (end_of_text on the string's last byte) and returns utf-16 code units, one per
// output transaction. a completed character gives one unit, or a surrogate pair
// with the high half first. on invalid input (bad lead or continuation, overlong
// form, surrogate code point, value above 0x10ffff, string cut short) a single
// result with bad_input and final_unit set and code_unit zero is returned, and the
// rest of that string is dropped silently up to its end_of_text byte.
// rate: one byte per cycle sustained while the output side keeps taking results;
// a surrogate pair takes two output transactions, so four-byte characters are
// bounded by the output port at one unit per cycle. the byte is registered,
// decoded against the character state in one pass and written to a four-entry
// result queue that drives the output, so the first result is offered once the
// byte has passed the input register and been written into the queue. the input
// stalls while a byte waits in the input register and the queue has fewer than
// two free entries. there is no configuration.

`include "utf8_to_utf16_transcoder_unit_macros.svh"

module utf8_to_utf16_transcoder_unit
  import u8u16_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // byte input
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  // code unit output
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // input register
  logic       stage_valid_q;
  in_item_t   stage_item_q;
  logic       stage_fire;
  logic       in_accept;

  // character state
  dec_state_t state_q, state_d;
  dec_push_t  dec_push;

  logic [QueueLvlW-1:0] queue_level;

  // the stage moves on when the queue can take a surrogate pair
  assign stage_fire = stage_valid_q && (queue_level <= QueueLvlW'(QueueDepth - 2));
  assign in_stall_o = stage_valid_q && !stage_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_accept) begin
      stage_valid_q <= 1'b1;
    end else if (stage_fire) begin
      stage_valid_q <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_item_q <= in_item_i;
    end
  end

  u8u16_decoder u_decoder (
    .item_i  (stage_item_q),
    .state_i (state_q),
    .state_o (state_d),
    .push_o  (dec_push)
  );

  // state advances only when the byte's results go into the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (stage_fire) begin
      state_q <= state_d;
    end
  end

  u8u16_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (stage_fire),
    .push_i      (dec_push),
    .level_o     (queue_level),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // queue never overfills
  `U8U16_ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, queue_level <= QueueLvlW'(QueueDepth))
  // an error result is always the last of its string and carries no unit
  `U8U16_ASSERT_IMPLIES(a_error_final, clk_i, rst_ni, out_valid_o && out_item_o.bad_input, out_item_o.final_unit && (out_item_o.code_unit == 16'd0))
  // nothing is produced while dropping the rest of a bad string
  `U8U16_ASSERT_IMPLIES(a_discard_quiet, clk_i, rst_ni, stage_fire && state_q.discarding, dec_push.res_count == ResNone)
  // a byte is taken into the stage only if the previous one left it
  `U8U16_ASSERT_IMPLIES(a_stage_no_drop, clk_i, rst_ni, in_accept && stage_valid_q, stage_fire)

endmodule
